// ----- src/rlu_pkg.sv -----
// ============================================================================
// rlu_pkg: shared types and constants of the radial lens undistortion remap
// Frame store geometry, fixed-point format, configuration register indexes
// and the structures that pass between the coordinate pipeline and the RAM.
// ============================================================================
package rlu_pkg;

    // Largest frame that the pixel store holds.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FB_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int FB_AW      = $clog2(FB_DEPTH);

    // Fraction bits of p2, of the coefficients and of the radial factor.
    localparam int FRAC = 28;

    // Register reset values, limited to the store size.
    localparam int WIDTH_RST  = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
    localparam int HEIGHT_RST = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_SQ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_K1      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_K2      = 3'd4;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_REMAP = 1'b1;

    typedef struct packed {
        logic        [8:0]  width;
        logic        [8:0]  height;
        logic        [39:0] inv_focal_sq;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
    } t_cfg;

    // One access to the pixel store, issued by the coordinate pipeline.
    typedef struct packed {
        logic             we;
        logic             rd;
        logic             hit;
        logic [FB_AW-1:0] addr;
        logic [31:0]      wdata;
    } t_mem_req;

endpackage

// ----- src/rlu_frame_ram.sv -----
// ============================================================================
// rlu_frame_ram: source pixel store
// Single-port synchronous RAM with registered read data and a shared
// clock enable that follows the pipeline stall.
// ============================================================================
module rlu_frame_ram (
    input  logic              i_clk,
    input  logic              i_en,
    input  rlu_pkg::t_mem_req i_req,
    output logic [31:0]       o_rdata
);

    logic [31:0] r_mem [rlu_pkg::FB_DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_req.we) begin
                r_mem[i_req.addr] <= i_req.wdata;
            end
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/rlu_coord_pipe.sv -----
// ============================================================================
// rlu_coord_pipe: source coordinate pipeline
// Eleven registered stages turn an output column and row into a store
// address and a hit flag; loads travel alongside so that every store access
// happens at the same stage and in arrival order.
// ============================================================================
module rlu_coord_pipe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_in_vld,
    input  logic              i_req_type,
    input  logic [7:0]        i_col,
    input  logic [7:0]        i_row,
    input  logic [31:0]       i_pixel,
    input  rlu_pkg::t_cfg     i_cfg,
    output rlu_pkg::t_mem_req o_req
);

    typedef struct packed {
        logic                     remap;
        logic                     ld_ok;
        logic [rlu_pkg::FB_AW-1:0] addr;
        logic [31:0]              wdata;
        logic signed [10:0]       hx;
        logic signed [10:0]       hy;
    } t_side;

    typedef struct packed {
        logic       hit;
        logic [8:0] pos;
    } t_coord;

    localparam logic signed [36:0] RP_ONE = 37'(1) << rlu_pkg::FRAC;

    // Truncates n / 2^(FRAC+1) toward zero and checks it against [0, lim).
    function automatic t_coord coord_chk(input logic signed [48:0] n, input logic [8:0] lim);
        t_coord             c;
        logic signed [48:0] neg;
        logic [19:0]        q;
        neg = -n;
        q   = n[48:rlu_pkg::FRAC+1];
        if (n[48]) begin
            c.hit = (neg[48:rlu_pkg::FRAC+1] == 20'd0) && (lim != 9'd0);
            c.pos = 9'd0;
        end else begin
            c.hit = (q < {11'd0, lim});
            c.pos = q[8:0];
        end
        return c;
    endfunction

    logic  [10:1] r_vld;
    t_side        r_side [10:1];

    logic        [19:0] r_ssum;
    logic        [59:0] r_prod;
    logic        [31:0] r_p2;
    logic        [31:0] r_p2_5;
    logic        [31:0] r_p2_6;
    logic signed [63:0] r_pk2;
    logic signed [31:0] r_inner;
    logic signed [63:0] r_pin;
    logic signed [36:0] r_rp;
    logic signed [47:0] r_mx;
    logic signed [47:0] r_my;
    logic signed [48:0] r_nx;
    logic signed [48:0] r_ny;
    rlu_pkg::t_mem_req  r_req;

    t_side              n_side;
    logic signed [21:0] n_sq_x;
    logic signed [21:0] n_sq_y;
    logic signed [21:0] n_sq_sum;
    logic        [59:0] n_prod;
    logic        [31:0] n_p2;
    logic signed [63:0] n_pk2;
    logic signed [36:0] n_inner_sum;
    logic signed [31:0] n_inner;
    logic signed [63:0] n_pin;
    logic signed [36:0] n_rp;
    logic signed [47:0] n_mx;
    logic signed [47:0] n_my;
    logic signed [48:0] n_nx;
    logic signed [48:0] n_ny;
    t_coord             n_cx;
    t_coord             n_cy;
    rlu_pkg::t_mem_req  n_req;

    always_comb begin
        // Stage 1: offsets from the frame centre in half pixels, load address.
        n_side.remap = (i_req_type == rlu_pkg::REQ_REMAP);
        n_side.ld_ok = (32'(i_col) < rlu_pkg::MAX_WIDTH) && (32'(i_row) < rlu_pkg::MAX_HEIGHT);
        n_side.addr  = rlu_pkg::FB_AW'(rlu_pkg::FB_AW'(i_row) * rlu_pkg::FB_AW'(rlu_pkg::MAX_WIDTH)
                     + rlu_pkg::FB_AW'(i_col));
        n_side.wdata = i_pixel;
        n_side.hx    = $signed({2'b00, i_col, 1'b0}) - $signed({2'b00, i_cfg.width});
        n_side.hy    = $signed({2'b00, i_row, 1'b0}) - $signed({2'b00, i_cfg.height});

        // Stage 2: squared radius.
        n_sq_x   = $signed(r_side[1].hx) * $signed(r_side[1].hx);
        n_sq_y   = $signed(r_side[1].hy) * $signed(r_side[1].hy);
        n_sq_sum = n_sq_x + n_sq_y;

        // Stage 3: scale by 1/f^2.
        n_prod = 60'(r_ssum) * 60'(i_cfg.inv_focal_sq);

        // Stage 4: drop 14 fraction bits and saturate to 32 bits.
        n_p2 = (|r_prod[59:46]) ? 32'hFFFF_FFFF : r_prod[45:14];

        // Stage 5: p2 * k2.
        n_pk2 = 64'($signed({1'b0, r_p2})) * 64'(i_cfg.k2);

        // Stage 6: inner = k1 + floor(p2*k2 / 2^28), saturated.
        n_inner_sum = 37'(i_cfg.k1) + 37'($signed(r_pk2[63:rlu_pkg::FRAC]));
        if (n_inner_sum[36:31] == 6'b000000 || n_inner_sum[36:31] == 6'b111111) begin
            n_inner = n_inner_sum[31:0];
        end else if (n_inner_sum[36]) begin
            n_inner = 32'sh8000_0000;
        end else begin
            n_inner = 32'sh7FFF_FFFF;
        end

        // Stage 7: p2 * inner.
        n_pin = 64'($signed({1'b0, r_p2_6})) * 64'(r_inner);

        // Stage 8: radial factor.
        n_rp = 37'($signed(r_pin[63:rlu_pkg::FRAC])) + RP_ONE;

        // Stage 9: scaled offsets.
        n_mx = 48'(r_rp) * 48'(r_side[8].hx);
        n_my = 48'(r_rp) * 48'(r_side[8].hy);

        // Stage 10: re-add the centre.
        n_nx = 49'(r_mx) + (49'($signed({1'b0, i_cfg.width})) <<< rlu_pkg::FRAC);
        n_ny = 49'(r_my) + (49'($signed({1'b0, i_cfg.height})) <<< rlu_pkg::FRAC);

        // Stage 11: bounds check and store access.
        n_cx = coord_chk(r_nx, i_cfg.width);
        n_cy = coord_chk(r_ny, i_cfg.height);
        n_req.we    = r_vld[10] && !r_side[10].remap && r_side[10].ld_ok;
        n_req.rd    = r_vld[10] && r_side[10].remap;
        n_req.hit   = n_cx.hit && n_cy.hit;
        n_req.wdata = r_side[10].wdata;
        if (r_side[10].remap) begin
            n_req.addr = rlu_pkg::FB_AW'(rlu_pkg::FB_AW'(n_cy.pos)
                       * rlu_pkg::FB_AW'(rlu_pkg::MAX_WIDTH) + rlu_pkg::FB_AW'(n_cx.pos));
        end else begin
            n_req.addr = r_side[10].addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_req.we <= 1'b0;
            r_req.rd <= 1'b0;
        end else if (i_en) begin
            r_vld <= {r_vld[9:1], i_in_vld};
            r_req <= n_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[1] <= n_side;
            for (int k = 2; k <= 10; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_ssum      <= n_sq_sum[19:0];
            r_prod      <= n_prod;
            r_p2        <= n_p2;
            r_p2_5      <= r_p2;
            r_p2_6      <= r_p2_5;
            r_pk2       <= n_pk2;
            r_inner     <= n_inner;
            r_pin       <= n_pin;
            r_rp        <= n_rp;
            r_mx        <= n_mx;
            r_my        <= n_my;
            r_nx        <= n_nx;
            r_ny        <= n_ny;
        end
    end

    assign o_req = r_req;

endmodule

// ----- src/radial_lens_undistort_remap.sv -----
// ============================================================================
// radial_lens_undistort_remap: two-coefficient radial undistortion remap
// A remap result passes the coordinate pipeline, store read and output registers.
// Throughput: one item per cycle (load or remap, single store port) unless stalled.
// Reset clears the pipeline and output valid flags and loads register defaults.
// ============================================================================
module radial_lens_undistort_remap (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic [7:0]                     i_col,
    input  logic [7:0]                     i_row,
    input  logic [31:0]                    i_pixel_in,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [31:0]                    o_pixel_out,
    output logic                           o_source_hit,
    // Configuration write port
    input  logic                           i_cfg_we,
    input  logic [rlu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rlu_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    // Configuration registers. The frame size is limited to the store size
    // as it is written, so the datapath never sees a larger frame.
    rlu_pkg::t_cfg r_cfg;
    logic [8:0]    n_width;
    logic [8:0]    n_height;

    always_comb begin
        n_width  = (32'(i_cfg_wdata[8:0]) > rlu_pkg::MAX_WIDTH)
                 ? 9'(rlu_pkg::MAX_WIDTH) : i_cfg_wdata[8:0];
        n_height = (32'(i_cfg_wdata[8:0]) > rlu_pkg::MAX_HEIGHT)
                 ? 9'(rlu_pkg::MAX_HEIGHT) : i_cfg_wdata[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width        <= 9'(rlu_pkg::WIDTH_RST);
            r_cfg.height       <= 9'(rlu_pkg::HEIGHT_RST);
            r_cfg.inv_focal_sq <= '1;
            r_cfg.k1           <= '0;
            r_cfg.k2           <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rlu_pkg::CFG_FRAME_WIDTH:  r_cfg.width        <= n_width;
                rlu_pkg::CFG_FRAME_HEIGHT: r_cfg.height       <= n_height;
                rlu_pkg::CFG_INV_FOCAL_SQ: r_cfg.inv_focal_sq <= i_cfg_wdata[39:0];
                rlu_pkg::CFG_COEF_K1:      r_cfg.k1           <= $signed(i_cfg_wdata[31:0]);
                rlu_pkg::CFG_COEF_K2:      r_cfg.k2           <= $signed(i_cfg_wdata[31:0]);
                default: ;
            endcase
        end
    end

    // The whole pipeline, store included, moves on one enable. It only halts
    // when a finished result sits at the store output while the output
    // register still holds one that has not been taken; bubbles and loads
    // keep flowing while a result waits.
    logic              w_en;
    rlu_pkg::t_mem_req w_req;
    logic [31:0]       w_rdata;
    logic              r_rd_vld;
    logic              r_rd_hit;
    logic              r_out_vld;
    logic [31:0]       r_out_pixel;
    logic              r_out_hit;

    assign w_en       = !r_rd_vld || !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    // Loads and remaps share one path, so the store sees writes and reads in
    // exactly the order that the input transfers arrived.
    rlu_coord_pipe u_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_in_vld   (i_in_valid),
        .i_req_type (i_req_type),
        .i_col      (i_col),
        .i_row      (i_row),
        .i_pixel    (i_pixel_in),
        .i_cfg      (r_cfg),
        .o_req      (w_req)
    );

    rlu_frame_ram u_ram (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    // Track which store read data belongs to a remap and whether it hit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (w_en) begin
            r_rd_vld <= w_req.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rd_hit <= w_req.hit;
        end
    end

    // Output register. A miss returns zero regardless of what was read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en && r_rd_vld) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_rd_vld) begin
            r_out_pixel <= r_rd_hit ? w_rdata : 32'd0;
            r_out_hit   <= r_rd_hit;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_pixel_out  = r_out_pixel;
    assign o_source_hit = r_out_hit;

endmodule

// ----- verif/tb_radial_lens_undistort_remap.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_radial_lens_undistort_remap: self-checking bench for the lens remap
// Loads source pixels and requests remapped pixels through the valid/ready
// channels under several register settings and idle patterns. Every remap
// result is compared with a fixed-point prediction of the source pixel.
// ============================================================================
module tb_radial_lens_undistort_remap;

    // An index that names no register; writes to it must change nothing.
    localparam logic [rlu_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;

    // One input transfer: a pixel load or a remap request.
    typedef struct {
        logic        req_type;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [31:0] pixel;
    } t_pixel_request;

    // One remap result as the block should return it.
    typedef struct {
        logic [31:0] pixel;
        logic        hit;
    } t_remap_result;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic                           in_req_type = rlu_pkg::REQ_LOAD;
    logic [7:0]                     in_col = '0;
    logic [7:0]                     in_row = '0;
    logic [31:0]                    in_pixel = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [31:0]                    out_pixel;
    logic                           out_hit;
    logic                           cfg_we = 1'b0;
    logic [rlu_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rlu_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    radial_lens_undistort_remap uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_req_type   (in_req_type),
        .i_col        (in_col),
        .i_row        (in_row),
        .i_pixel_in   (in_pixel),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_pixel_out  (out_pixel),
        .o_source_hit (out_hit),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata)
    );

    // 100 MHz clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the registers, kept in the form the datapath uses them.
    longint     cfg_width  = rlu_pkg::WIDTH_RST;
    longint     cfg_height = rlu_pkg::HEIGHT_RST;
    logic [39:0] cfg_inv_f2 = 40'hFF_FFFF_FFFF;
    longint     cfg_k1 = 0;
    longint     cfg_k2 = 0;

    // Pixel store as the block should hold it, and the set of entries that
    // the stimulus has already loaded (a remap may only read those).
    logic [31:0] frame_copy [rlu_pkg::FB_DEPTH];
    bit          frame_loaded [rlu_pkg::FB_DEPTH];

    t_pixel_request pending_requests[$];
    t_remap_result  expected_pixels[$];

    int  requests_queued   = 0;
    int  requests_accepted = 0;
    int  error_count       = 0;
    int  src_idle_pct      = 0;
    int  sink_stall_pct    = 0;
    bit  in_taken          = 1'b0;

    // Maps an output pixel to its source pixel with the current registers.
    // Offsets are kept in half pixels so that odd frame sizes stay exact;
    // p2, the coefficients and the radial factor carry 28 fraction bits.
    function automatic void map_source(input logic [7:0] col, input logic [7:0] row,
                                       output logic hit, output logic [7:0] src_col,
                                       output logic [7:0] src_row);
        longint          hx, hy, p2, inner, rp, nx, ny, sx, sy;
        longint unsigned sq, prod;
        hx = 2 * longint'(col) - cfg_width;
        hy = 2 * longint'(row) - cfg_height;
        sq = hx * hx + hy * hy;
        prod = (sq * cfg_inv_f2) >> 14;
        p2 = (prod > 64'd4294967295) ? 64'sd4294967295 : longint'(prod);
        // The inner term k1 + p2*k2 saturates to the 32-bit coefficient range.
        inner = cfg_k1 + ((p2 * cfg_k2) >>> rlu_pkg::FRAC);
        if (inner > 64'sd2147483647) begin
            inner = 64'sd2147483647;
        end
        if (inner < -64'sd2147483648) begin
            inner = -64'sd2147483648;
        end
        rp = (64'sd1 <<< rlu_pkg::FRAC) + ((p2 * inner) >>> rlu_pkg::FRAC);
        nx = rp * hx + cfg_width * (64'sd1 <<< rlu_pkg::FRAC);
        ny = rp * hy + cfg_height * (64'sd1 <<< rlu_pkg::FRAC);
        // Signed division truncates toward zero, so a coordinate just below
        // zero lands on column or row 0 and still counts as inside.
        sx = nx / (64'sd1 <<< (rlu_pkg::FRAC + 1));
        sy = ny / (64'sd1 <<< (rlu_pkg::FRAC + 1));
        hit = (sx >= 0) && (sx < cfg_width) && (sy >= 0) && (sy < cfg_height);
        src_col = sx[7:0];
        src_row = sy[7:0];
    endfunction

    // Applies one accepted transfer to the shadow store or queues its result.
    function automatic void predict_transfer(input t_pixel_request req);
        logic          hit;
        logic [7:0]    sc, sr;
        t_remap_result res;
        if (req.req_type == rlu_pkg::REQ_LOAD) begin
            frame_copy[req.row * rlu_pkg::MAX_WIDTH + req.col] = req.pixel;
        end else begin
            map_source(req.col, req.row, hit, sc, sr);
            res.hit   = hit;
            res.pixel = hit ? frame_copy[sr * rlu_pkg::MAX_WIDTH + sc] : 32'd0;
            expected_pixels = {expected_pixels, res};
        end
    endfunction

    // Driver: a new request is presented at the falling edge once the
    // previous one has been transferred; idling is decided per cycle.
    always @(negedge clk) begin
        t_pixel_request nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                nxt = pending_requests.pop_front();
                in_req_type <= nxt.req_type;
                in_col      <= nxt.col;
                in_row      <= nxt.row;
                in_pixel    <= nxt.pixel;
                in_valid    <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // The result side stalls at random with the current stall rate.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Monitor: records input transfers for the predictor and checks every
    // result transfer against the oldest expected pixel.
    always @(posedge clk) begin
        t_pixel_request req;
        t_remap_result  want;
        if (!rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready) begin
                req.req_type = in_req_type;
                req.col      = in_col;
                req.row      = in_row;
                req.pixel    = in_pixel;
                predict_transfer(req);
                requests_accepted++;
            end
            if (out_valid && out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result: pixel_out %h source_hit %b", out_pixel, out_hit);
                    error_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (out_pixel !== want.pixel) begin
                        $error("pixel_out: expected %h, actual %h", want.pixel, out_pixel);
                        error_count++;
                    end
                    if (out_hit !== want.hit) begin
                        $error("source_hit: expected %b, actual %b", want.hit, out_hit);
                        error_count++;
                    end
                end
            end
        end
    end

    // Register write at the falling edge; the shadow copy follows at once,
    // which is safe because writes only happen while the block is idle.
    task automatic write_reg(input logic [rlu_pkg::CFG_IDX_W-1:0] idx, input logic [39:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            rlu_pkg::CFG_FRAME_WIDTH: begin
                cfg_width = (value[8:0] > rlu_pkg::MAX_WIDTH) ? rlu_pkg::MAX_WIDTH : value[8:0];
            end
            rlu_pkg::CFG_FRAME_HEIGHT: begin
                cfg_height = (value[8:0] > rlu_pkg::MAX_HEIGHT)
                           ? rlu_pkg::MAX_HEIGHT : value[8:0];
            end
            rlu_pkg::CFG_INV_FOCAL_SQ: cfg_inv_f2 = value;
            rlu_pkg::CFG_COEF_K1:      cfg_k1 = longint'($signed(value[31:0]));
            rlu_pkg::CFG_COEF_K2:      cfg_k2 = longint'($signed(value[31:0]));
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Writes all five registers; unused upper data bits carry random junk
    // that the block has to ignore.
    task automatic load_settings(input logic [8:0] w, input logic [8:0] h,
                                 input logic [39:0] inv_f2, input logic [31:0] k1,
                                 input logic [31:0] k2);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(rlu_pkg::CFG_FRAME_WIDTH,  {junk[39:9], w});
        write_reg(rlu_pkg::CFG_FRAME_HEIGHT, {junk[49:19], h});
        write_reg(rlu_pkg::CFG_INV_FOCAL_SQ, inv_f2);
        write_reg(rlu_pkg::CFG_COEF_K1,      {junk[63:56], k1});
        write_reg(rlu_pkg::CFG_COEF_K2,      {junk[7:0], k2});
    endtask

    task automatic queue_load(input logic [7:0] col, input logic [7:0] row,
                              input logic [31:0] pixel);
        t_pixel_request req;
        req.req_type = rlu_pkg::REQ_LOAD;
        req.col      = col;
        req.row      = row;
        req.pixel    = pixel;
        frame_loaded[row * rlu_pkg::MAX_WIDTH + col] = 1'b1;
        pending_requests = {pending_requests, req};
        requests_queued++;
    endtask

    // A remap whose source pixel was never loaded is preceded by a load of
    // that pixel, so that no read of an unwritten store entry is caused.
    task automatic queue_remap(input logic [7:0] col, input logic [7:0] row);
        t_pixel_request req;
        logic           hit;
        logic [7:0]     sc, sr;
        map_source(col, row, hit, sc, sr);
        if (hit && !frame_loaded[sr * rlu_pkg::MAX_WIDTH + sc]) begin
            queue_load(sc, sr, $urandom);
        end
        req.req_type = rlu_pkg::REQ_REMAP;
        req.col      = col;
        req.row      = row;
        req.pixel    = $urandom;
        pending_requests = {pending_requests, req};
        requests_queued++;
    endtask

    // Mostly loads and remaps inside the current frame, with some of both
    // anywhere in the 8-bit coordinate space.
    task automatic random_traffic(input int count);
        int w_lim, h_lim, kind;
        w_lim = (cfg_width > 0) ? int'(cfg_width) : 1;
        h_lim = (cfg_height > 0) ? int'(cfg_height) : 1;
        repeat (count) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                queue_load(8'($urandom_range(0, w_lim - 1)), 8'($urandom_range(0, h_lim - 1)),
                           $urandom);
            end else if (kind < 36) begin
                queue_load(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom);
            end else if (kind < 86) begin
                queue_remap(8'($urandom_range(0, w_lim - 1)), 8'($urandom_range(0, h_lim - 1)));
            end else begin
                queue_remap(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Waits until every queued request has been transferred and every
    // expected result has arrived, then lets the pipeline run empty, since
    // loads produce no result that would show they are done.
    task automatic drain();
        while (requests_accepted != requests_queued || expected_pixels.size() != 0) begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings give an identity mapping: corners and extreme pixels.
        queue_load(8'd0, 8'd0, 32'h0000_0000);
        queue_load(8'd255, 8'd255, 32'hFFFF_FFFF);
        queue_load(8'd255, 8'd0, 32'hA5A5_A5A5);
        queue_load(8'd0, 8'd255, 32'h5A5A_5A5A);
        queue_remap(8'd0, 8'd0);
        queue_remap(8'd255, 8'd255);
        queue_remap(8'd255, 8'd0);
        queue_remap(8'd0, 8'd255);
        queue_remap(8'd128, 8'd128);
        drain();

        // A zero frame size makes every remap miss.
        load_settings(9'd0, 9'd0, 40'hFF_FFFF_FFFF, 32'd0, 32'd0);
        queue_remap(8'd0, 8'd0);
        queue_remap(8'd255, 8'd255);
        drain();

        // A 2x2 frame with k1 = 0.5: column 0 maps just below zero and must
        // truncate to column 0; column 200 lies far outside the frame.
        load_settings(9'd2, 9'd2, 40'hFF_FFFF_FFFF, 32'h0800_0000, 32'd0);
        write_reg(CFG_IDX_SPARE, {$urandom, $urandom});
        queue_remap(8'd0, 8'd1);
        queue_remap(8'd200, 8'd1);
        queue_remap(8'd1, 8'd1);
        queue_remap(8'd0, 8'd0);
        drain();

        // Oversized width and height saturate to the store size; moderate
        // distortion. Half way through, the sender waits for all results.
        load_settings(9'd300, 9'd511, 40'd33554432 + $urandom_range(0, 1 << 24),
                      32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000,
                      32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000);
        random_traffic(70);
        drain();
        random_traffic(70);
        drain();

        // Small frame, extreme coefficients, sender idling.
        src_idle_pct = 50;
        load_settings(9'($urandom_range(8, 24)), 9'($urandom_range(8, 24)),
                      40'($urandom_range(1 << 20, 1 << 30)), 32'h8000_0000, 32'h7FFF_FFFF);
        random_traffic(140);
        drain();

        // One-pixel-wide frame, no focal term, opposite extreme coefficients,
        // receiver stalling.
        src_idle_pct   = 0;
        sink_stall_pct = 50;
        load_settings(9'd1, 9'd256, 40'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        random_traffic(60);
        drain();

        // Random frame and coefficients with both sides idling.
        src_idle_pct   = 26;
        sink_stall_pct = 26;
        load_settings(9'($urandom_range(20, 64)), 9'($urandom_range(20, 64)),
                      {8'd0, $urandom} << $urandom_range(0, 6), $urandom, $urandom);
        random_traffic(140);
        drain();

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
